[hdl/caenp_pkg.sv]
// Shared types, constants and register indexes of the ADC event word parser.
package caenp_pkg;

  // Default hit limit per kind and per event
  localparam int MAX_HITS_DEF = 64;

  localparam int WORD_W  = 16;
  localparam int CFG_IW  = 3;
  localparam int CFG_DW  = 32;
  localparam int GEO_W   = 5;
  localparam int CNT_OUT_W = 7;
  localparam int EOB_W   = 25;
  localparam int TOTAL_W = 32;
  localparam int VAL_W   = 14;
  localparam int MOD_W   = 6;
  localparam int CH_W    = 5;

  localparam int OUT_DATA_W = 96;
  localparam int OUT_USER_W = 2;

  localparam logic [WORD_W-1:0] FILL_WORD = 16'hffff;
  localparam logic signed [VAL_W-1:0] VAL_OVERFLOW  = 14'sd5000;
  localparam logic signed [VAL_W-1:0] VAL_UNDERFLOW = -14'sd1000;
  localparam logic [MOD_W-1:0] TDC_GEO_OFFSET = 6'd10;

  // Configuration register indexes
  localparam logic [CFG_IW-1:0] REG_ADC_MODULE_A = 3'd0;
  localparam logic [CFG_IW-1:0] REG_ADC_MASK_A   = 3'd1;
  localparam logic [CFG_IW-1:0] REG_ADC_MODULE_B = 3'd2;
  localparam logic [CFG_IW-1:0] REG_ADC_MASK_B   = 3'd3;
  localparam logic [CFG_IW-1:0] REG_TDC_MODULE   = 3'd4;
  localparam logic [CFG_IW-1:0] REG_TDC_MASK     = 3'd5;

  typedef struct packed {
    logic [GEO_W-1:0] adc_module_a;
    logic [31:0]      adc_mask_a;
    logic [GEO_W-1:0] adc_module_b;
    logic [31:0]      adc_mask_b;
    logic [GEO_W-1:0] tdc_module;
    logic [31:0]      tdc_mask;
  } cfg_t;

  typedef struct packed {
    logic                    hit_valid;
    logic                    hit_is_tdc;
    logic signed [MOD_W-1:0] module_id;
    logic [CH_W-1:0]         channel;
    logic signed [VAL_W-1:0] value;
    logic                    event_end;
    logic [CNT_OUT_W-1:0]    adc_hit_count;
    logic [CNT_OUT_W-1:0]    tdc_hit_count;
    logic [EOB_W-1:0]        eob_event_number;
    logic [TOTAL_W-1:0]      events_done;
  } res_t;

endpackage

[hdl/caenp_cfg.sv]
// Configuration register file of the ADC event word parser.
module caenp_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [caenp_pkg::CFG_IW-1:0] wr_index,
  input  logic [caenp_pkg::CFG_DW-1:0] wr_data,
  output caenp_pkg::cfg_t              cfg
);

  caenp_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.adc_module_a <= 5'd2;
      cfg_r.adc_mask_a   <= 32'hffff_ffff;
      cfg_r.adc_module_b <= 5'd3;
      cfg_r.adc_mask_b   <= 32'h1100_ffff;
      cfg_r.tdc_module   <= 5'd12;
      cfg_r.tdc_mask     <= 32'h0000_0081;
    end else if (wr_en) begin
      case (wr_index)
        caenp_pkg::REG_ADC_MODULE_A: cfg_r.adc_module_a <= wr_data[caenp_pkg::GEO_W-1:0];
        caenp_pkg::REG_ADC_MASK_A:   cfg_r.adc_mask_a   <= wr_data;
        caenp_pkg::REG_ADC_MODULE_B: cfg_r.adc_module_b <= wr_data[caenp_pkg::GEO_W-1:0];
        caenp_pkg::REG_ADC_MASK_B:   cfg_r.adc_mask_b   <= wr_data;
        caenp_pkg::REG_TDC_MODULE:   cfg_r.tdc_module   <= wr_data[caenp_pkg::GEO_W-1:0];
        caenp_pkg::REG_TDC_MASK:     cfg_r.tdc_mask     <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[hdl/caenp_parse.sv]
// Word parser: phase state, hit filtering and per-event counters.
module caenp_parse #(
  parameter int MAX_HITS = caenp_pkg::MAX_HITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         word_en,
  input  logic [caenp_pkg::WORD_W-1:0] word,
  input  caenp_pkg::cfg_t              cfg,
  output logic                         res_valid,
  output caenp_pkg::res_t              res
);

  localparam int CNT_NEED = $clog2(MAX_HITS + 1);
  localparam int CNT_W = (CNT_NEED > caenp_pkg::CNT_OUT_W) ? CNT_NEED : caenp_pkg::CNT_OUT_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_HITS);

  typedef enum logic [2:0] {
    PH_LEN, PH_HDR1, PH_HDR2, PH_DLO, PH_DHI, PH_EOBL, PH_EOBH
  } phase_t;

  phase_t                         phase_r, phase_nxt;
  logic [15:0]                    len_r, len_nxt;
  logic [16:0]                    words_r, words_nxt;
  logic [7:0]                     chans_r, chans_nxt, chans_dec;
  logic [caenp_pkg::GEO_W-1:0]    hdr_mod_r, hdr_mod_nxt;
  logic [13:0]                    pend_r, pend_nxt;
  logic [15:0]                    eob_low_r, eob_low_nxt;
  logic [CNT_W-1:0]               adc_cnt_r, adc_cnt_nxt, adc_cnt_upd;
  logic [CNT_W-1:0]               tdc_cnt_r, tdc_cnt_nxt, tdc_cnt_upd;
  logic [caenp_pkg::EOB_W-1:0]    eob_num_r, eob_num_nxt;
  logic [caenp_pkg::TOTAL_W-1:0]  total_r, total_nxt;

  logic [caenp_pkg::GEO_W-1:0] geo;
  logic [caenp_pkg::CH_W-1:0]  ch;
  logic                        adc_ok, tdc_ok, hit, is_tdc, ev_end;
  logic signed [caenp_pkg::VAL_W-1:0] val;

  assign geo = word[15:11];
  assign ch  = word[4:0];
  assign chans_dec = chans_r - 8'd1;

  assign adc_ok = (hdr_mod_r == cfg.adc_module_a && cfg.adc_mask_a[ch]) ||
                  (hdr_mod_r == cfg.adc_module_b && cfg.adc_mask_b[ch]);
  assign tdc_ok = (hdr_mod_r == cfg.tdc_module) && cfg.tdc_mask[ch];

  always_comb begin
    phase_nxt   = phase_r;
    len_nxt     = len_r;
    words_nxt   = words_r + 17'd1;
    chans_nxt   = chans_r;
    hdr_mod_nxt = hdr_mod_r;
    pend_nxt    = pend_r;
    eob_low_nxt = eob_low_r;
    adc_cnt_upd = adc_cnt_r;
    tdc_cnt_upd = tdc_cnt_r;
    eob_num_nxt = eob_num_r;
    hit         = 1'b0;
    is_tdc      = 1'b0;
    val         = '0;
    case (phase_r)
      PH_LEN: begin
        len_nxt   = word;
        words_nxt = 17'd1;
        phase_nxt = PH_HDR1;
      end
      PH_HDR1: begin
        // skip fill words where a block may start
        if (word != caenp_pkg::FILL_WORD) begin
          chans_nxt = word[15:8];
          phase_nxt = PH_HDR2;
        end
      end
      PH_HDR2: begin
        hdr_mod_nxt = geo;
        phase_nxt   = (chans_r != 8'd0) ? PH_DLO : PH_EOBL;
      end
      PH_DLO: begin
        pend_nxt  = word[13:0];
        phase_nxt = PH_DHI;
      end
      PH_DHI: begin
        chans_nxt = chans_dec;
        phase_nxt = (chans_dec != 8'd0) ? PH_DLO : PH_EOBL;
        if (geo == hdr_mod_r) begin
          if (adc_ok) begin
            if (adc_cnt_r < CNT_MAX) begin
              adc_cnt_upd = adc_cnt_r + CNT_W'(1);
              hit = 1'b1;
              if (pend_r[12])      val = caenp_pkg::VAL_OVERFLOW;
              else if (pend_r[13]) val = caenp_pkg::VAL_UNDERFLOW;
              else                 val = $signed({2'b00, pend_r[11:0]});
            end
          end else if (tdc_ok) begin
            if (tdc_cnt_r < CNT_MAX) begin
              tdc_cnt_upd = tdc_cnt_r + CNT_W'(1);
              hit    = 1'b1;
              is_tdc = 1'b1;
              val    = $signed({2'b00, pend_r[11:0]});
            end
          end
        end
      end
      PH_EOBL: begin
        eob_low_nxt = word;
        phase_nxt   = PH_EOBH;
      end
      PH_EOBH: begin
        if (geo == hdr_mod_r && word[10])
          eob_num_nxt = {1'b0, word[7:0], eob_low_r} + 25'd1;
        phase_nxt = PH_HDR1;
      end
      default: phase_nxt = PH_LEN;
    endcase

    ev_end    = (words_nxt >= {1'b0, len_nxt});
    total_nxt = ev_end ? total_r + 32'd1 : total_r;

    res.hit_valid        = hit;
    res.hit_is_tdc       = is_tdc;
    res.module_id        = hit ? (is_tdc ? $signed({1'b0, hdr_mod_r} - caenp_pkg::TDC_GEO_OFFSET)
                                         : $signed({1'b0, hdr_mod_r}))
                               : '0;
    res.channel          = hit ? ch : '0;
    res.value            = val;
    res.event_end        = ev_end;
    res.adc_hit_count    = adc_cnt_upd[caenp_pkg::CNT_OUT_W-1:0];
    res.tdc_hit_count    = tdc_cnt_upd[caenp_pkg::CNT_OUT_W-1:0];
    res.eob_event_number = eob_num_nxt;
    res.events_done      = total_nxt;
    res_valid            = hit || ev_end;

    // close the event: clear per-event state
    adc_cnt_nxt = adc_cnt_upd;
    tdc_cnt_nxt = tdc_cnt_upd;
    if (ev_end) begin
      phase_nxt   = PH_LEN;
      adc_cnt_nxt = '0;
      tdc_cnt_nxt = '0;
      chans_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_LEN;
      len_r     <= '0;
      words_r   <= '0;
      chans_r   <= '0;
      hdr_mod_r <= '0;
      pend_r    <= '0;
      eob_low_r <= '0;
      adc_cnt_r <= '0;
      tdc_cnt_r <= '0;
      eob_num_r <= '0;
      total_r   <= '0;
    end else if (word_en) begin
      phase_r   <= phase_nxt;
      len_r     <= len_nxt;
      words_r   <= words_nxt;
      chans_r   <= chans_nxt;
      hdr_mod_r <= hdr_mod_nxt;
      pend_r    <= pend_nxt;
      eob_low_r <= eob_low_nxt;
      adc_cnt_r <= adc_cnt_nxt;
      tdc_cnt_r <= tdc_cnt_nxt;
      eob_num_r <= eob_num_nxt;
      total_r   <= total_nxt;
    end
  end

endmodule

[hdl/caenp_outq.sv]
// Result register with a skid entry so the parser can hand over one more result while the sink stalls.
module caenp_outq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  caenp_pkg::res_t push_res,
  output logic            can_push,
  output logic            out_valid,
  input  logic            out_ready,
  output caenp_pkg::res_t out_res
);

  logic            head_vld_r, skid_vld_r;
  caenp_pkg::res_t head_r, skid_r;
  logic            pop;

  assign pop      = head_vld_r && out_ready;
  assign can_push = !skid_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (pop) begin
        skid_vld_r <= 1'b0;
      end
    end else if (head_vld_r && !pop) begin
      if (push) begin
        skid_vld_r <= 1'b1;
      end
    end else begin
      head_vld_r <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (pop) begin
        head_r <= skid_r;
      end
    end else if (head_vld_r && !pop) begin
      if (push) begin
        skid_r <= push_res;
      end
    end else if (push) begin
      head_r <= push_res;
    end
  end

  assign out_valid = head_vld_r;
  assign out_res   = head_r;

endmodule

[hdl/caen_adc_event_word_parser.sv]
// Top level of the ADC event word parser: ports, packing and submodule wiring.
//
// Usage:
//   in_*   : stream of 16-bit event words, length word first (count includes itself),
//            then module blocks (channel-count header, GEO header, data pairs, two
//            end-of-block words). Fill words 0xffff between blocks are skipped.
//   out_*  : one request per word that completes an accepted hit or ends the event.
//            tuser flags hit/kind, tlast marks the word that closed the event.
//   cfg_*  : register writes (index 0..5), always ready; write only while idle.
// Output: each result is registered in the result register, or in the skid entry, before it shows on out_*.
// Throughput: one word per cycle while the skid entry is empty; the phase update and hit filter sit between the
//   parser state registers and the result register in a single pass.
// Stall: a skid entry behind the result register takes one more result while the
//   receiver holds out_tready low; in_tready drops only while that entry is full.
// Reset (rst_n low, synchronous): parser expects a length word, counters clear,
//   registers return to their defaults and pending results are dropped.
module caen_adc_event_word_parser #(
  parameter int MAX_HITS = caenp_pkg::MAX_HITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input word stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [caenp_pkg::WORD_W-1:0]     in_tdata,   // [15:0] word
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [5:0] module_id, [10:6] channel, [24:11] value, [31:25] adc_hit_count,
  // [38:32] tdc_hit_count, [63:39] eob_event_number, [95:64] events_done
  output logic [caenp_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [caenp_pkg::OUT_USER_W-1:0] out_tuser,  // [0] hit_valid, [1] hit_is_tdc
  output logic                             out_tlast,  // event_end
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [caenp_pkg::CFG_IW-1:0]     cfg_index,
  input  logic [caenp_pkg::CFG_DW-1:0]     cfg_data
);

  caenp_pkg::cfg_t cfg;
  caenp_pkg::res_t step_res, head_res;
  logic            step_vld, word_acc, can_push;

  // registers never push back
  assign cfg_ready = 1'b1;

  caenp_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // accept a word whenever the result side has room for what it may produce
  assign in_tready = can_push;
  assign word_acc  = in_tvalid && can_push;

  caenp_parse #(
    .MAX_HITS (MAX_HITS)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .word_en   (word_acc),
    .word      (in_tdata),
    .cfg       (cfg),
    .res_valid (step_vld),
    .res       (step_res)
  );

  caenp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (word_acc && step_vld),
    .push_res  (step_res),
    .can_push  (can_push),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (head_res)
  );

  // pack the result request
  assign out_tdata = {head_res.events_done,
                      head_res.eob_event_number,
                      head_res.tdc_hit_count,
                      head_res.adc_hit_count,
                      head_res.value,
                      head_res.channel,
                      head_res.module_id};
  assign out_tuser = {head_res.hit_is_tdc, head_res.hit_valid};
  assign out_tlast = head_res.event_end;

endmodule
